### rtl/core/crf_pkg.sv
// shared types and constants for the control register file
package crf_pkg;

  typedef enum logic [2:0] {
    OP_READ_CR   = 3'd0,
    OP_WRITE_CR  = 3'd1,
    OP_READ_SP   = 3'd2,
    OP_WRITE_SP  = 3'd3,
    OP_READ_PSW  = 3'd4,
    OP_WRITE_PSW = 3'd5
  } op_t;

  localparam logic [3:0] CR_PSW   = 4'd0;
  localparam logic [3:0] CR_CBR   = 4'd1;
  localparam logic [3:0] CR_SPI   = 4'd2;
  localparam logic [3:0] CR_SPU   = 4'd3;
  localparam logic [3:0] CR_SPARE0 = 4'd4;
  localparam logic [3:0] CR_SPARE1 = 4'd5;
  localparam logic [3:0] CR_BPC   = 4'd6;
  localparam logic [3:0] CR_BBPSW = 4'd8;
  localparam logic [3:0] CR_BBPC  = 4'd14;

  localparam int unsigned SM_BIT = 7;

  localparam logic [7:0]  BACKUP_PSW_MASK = 8'hc1;
  localparam logic [7:0]  PSW_CR_MASK     = 8'hc0;
  localparam logic [7:0]  PSW_BYTE_MASK   = 8'hfe;
  localparam logic [31:0] PC_MASK         = 32'hffff_fffe;

  typedef struct packed {
    op_t         op;
    logic [3:0]  num;
    logic [31:0] value;
  } access_t;

endpackage

### rtl/core/crf_regfile.sv
// control register state with banked stack pointer and access decode
module crf_regfile
  import crf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  access_t     acc,
  output logic [31:0] rd_data
);

  logic [7:0]  psw, psw_next;
  logic [7:0]  bpsw, bpsw_next;
  logic [7:0]  bbpsw, bbpsw_next;
  logic        cond, cond_next;
  logic [31:0] sp, sp_next;
  logic [31:0] spi, spi_next;
  logic [31:0] spu, spu_next;
  logic [31:0] bpc, bpc_next;
  logic [31:0] bbpc, bbpc_next;
  logic [31:0] spare0, spare0_next;
  logic [31:0] spare1, spare1_next;
  logic        sm;
  logic [31:0] cr_rd;

  assign sm = psw[SM_BIT];

  always_comb begin
    case (acc.num)
      CR_PSW:    cr_rd = {16'h0, bpsw & BACKUP_PSW_MASK, (psw & PSW_CR_MASK) | {7'd0, cond}};
      CR_CBR:    cr_rd = {31'd0, cond};
      CR_SPI:    cr_rd = sm ? spi : sp;
      CR_SPU:    cr_rd = sm ? sp : spu;
      CR_SPARE0: cr_rd = spare0;
      CR_SPARE1: cr_rd = spare1;
      CR_BPC:    cr_rd = bpc & PC_MASK;
      CR_BBPSW:  cr_rd = {24'd0, bbpsw & BACKUP_PSW_MASK};
      CR_BBPC:   cr_rd = bbpc & PC_MASK;
      default:   cr_rd = '0;
    endcase
  end

  always_comb begin
    psw_next    = psw;
    bpsw_next   = bpsw;
    bbpsw_next  = bbpsw;
    cond_next   = cond;
    sp_next     = sp;
    spi_next    = spi;
    spu_next    = spu;
    bpc_next    = bpc;
    bbpc_next   = bbpc;
    spare0_next = spare0;
    spare1_next = spare1;
    rd_data     = '0;
    unique case (acc.op)
      OP_READ_CR: begin
        rd_data = cr_rd;
      end
      OP_WRITE_CR: begin
        unique case (acc.num)
          CR_PSW: begin
            bpsw_next = acc.value[15:8];
            psw_next  = acc.value[7:0];
            cond_next = acc.value[0];
            // bank swap on stack mode change
            if (sm != acc.value[SM_BIT]) begin
              if (sm) begin
                spu_next = sp;
                sp_next  = spi;
              end else begin
                spi_next = sp;
                sp_next  = spu;
              end
            end
          end
          CR_CBR: cond_next = acc.value[0];
          CR_SPI: begin
            if (sm) spi_next = acc.value;
            else sp_next = acc.value;
          end
          CR_SPU: begin
            if (sm) sp_next = acc.value;
            else spu_next = acc.value;
          end
          CR_SPARE0: spare0_next = acc.value;
          CR_SPARE1: spare1_next = acc.value;
          CR_BPC:    bpc_next = acc.value;
          CR_BBPSW:  bbpsw_next = acc.value[7:0];
          CR_BBPC:   bbpc_next = acc.value;
          default: begin
          end
        endcase
      end
      OP_READ_SP: begin
        rd_data = sp;
      end
      OP_WRITE_SP: begin
        sp_next = acc.value;
      end
      OP_READ_PSW: begin
        rd_data = {24'd0, (psw & PSW_BYTE_MASK) | {7'd0, cond}};
      end
      OP_WRITE_PSW: begin
        psw_next  = acc.value[7:0];
        cond_next = acc.value[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      psw    <= '0;
      bpsw   <= '0;
      bbpsw  <= '0;
      cond   <= 1'b0;
      sp     <= '0;
      spi    <= '0;
      spu    <= '0;
      bpc    <= '0;
      bbpc   <= '0;
      spare0 <= '0;
      spare1 <= '0;
    end else if (step) begin
      psw    <= psw_next;
      bpsw   <= bpsw_next;
      bbpsw  <= bbpsw_next;
      cond   <= cond_next;
      sp     <= sp_next;
      spi    <= spi_next;
      spu    <= spu_next;
      bpc    <= bpc_next;
      bbpc   <= bbpc_next;
      spare0 <= spare0_next;
      spare1 <= spare1_next;
    end
  end

endmodule

### rtl/core/control_register_file_banked_sp.sv
// top level: input register, control register access, result register
// an accepted word is held in the input register, and its result word in the result register
// throughput: one word per cycle while the result is not stalled, set by the single access stage
// a stalled result holds the access stage, which then stalls the input
// reset clears every control register and both valid flags
module control_register_file_banked_sp
  import crf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  reg_number,
  input  logic [31:0] write_value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_value
);

  logic        s1_valid;
  access_t     s1_acc;
  logic        load_out;
  logic [31:0] rd_data;

  assign load_out  = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !load_out;

  crf_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_valid && load_out),
    .acc     (s1_acc),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (!req_stall) s1_valid <= req_valid;
      if (load_out) rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_acc.op    <= op_t'(operation);
      s1_acc.num   <= reg_number;
      s1_acc.value <= write_value;
    end
    if (load_out && s1_valid) read_value <= rd_data;
  end

endmodule

### rtl/core/crf_checker.sv
// port-level checks for the control register file, bound to the top level
module crf_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] read_value
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without a stalled result");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("accepted word did not reach the output");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind control_register_file_banked_sp crf_checker u_crf_checker (.*);

### tb/sv/tb_control_register_file_banked_sp.sv
// self-checking testbench for the banked stack pointer control register file
module tb_control_register_file_banked_sp;
  import crf_pkg::*;

  localparam logic [2:0] OP_RSVD6    = 3'd6;
  localparam logic [2:0] OP_RSVD7    = 3'd7;
  localparam logic [3:0] CR_UNUSED15 = 4'd15;
  localparam int         N_DIRECTED  = 27;
  localparam int         N_RANDOM    = 1000;
  localparam int         MAX_IDLE    = 14;
  localparam int         SETTLE      = 10;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  num;
    logic [31:0] value;
    logic        typed;
    logic [31:0] read;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [2:0]  operation;
  logic [3:0]  reg_number;
  logic [31:0] write_value;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [31:0] read_value;

  // predicted register state
  logic [7:0]  psw_q     = '0;
  logic [7:0]  bpsw_q    = '0;
  logic [7:0]  bbpsw_q   = '0;
  logic        cond_q    = 1'b0;
  logic [31:0] sp_live_q = '0;
  logic [31:0] sp_int_q  = '0;
  logic [31:0] sp_usr_q  = '0;
  logic [31:0] bpc_q     = '0;
  logic [31:0] bbpc_q    = '0;
  logic [31:0] spare_q [2] = '{32'h0, 32'h0};

  logic [31:0] pending_reads [$];
  int          fail_count      = 0;
  bit          fast_stretch    = 1'b0;
  int          rsp_hold_cycles = 0;

  control_register_file_banked_sp u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .reg_number  (reg_number),
    .write_value (write_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_value  (read_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] next_read_value(logic [2:0] op, logic [3:0] num,
                                                  logic [31:0] v);
    logic [31:0] r;
    logic        old_mode;
    r = '0;
    case (op)
      OP_READ_CR: begin
        case (num)
          CR_PSW:    r = {16'h0, bpsw_q & BACKUP_PSW_MASK,
                          (psw_q & PSW_CR_MASK) | {7'h0, cond_q}};
          CR_CBR:    r = {31'h0, cond_q};
          CR_SPI:    r = psw_q[SM_BIT] ? sp_int_q : sp_live_q;
          CR_SPU:    r = psw_q[SM_BIT] ? sp_live_q : sp_usr_q;
          CR_SPARE0: r = spare_q[0];
          CR_SPARE1: r = spare_q[1];
          CR_BPC:    r = bpc_q & PC_MASK;
          CR_BBPSW:  r = {24'h0, bbpsw_q & BACKUP_PSW_MASK};
          CR_BBPC:   r = bbpc_q & PC_MASK;
          default:   r = '0;
        endcase
      end
      OP_WRITE_CR: begin
        case (num)
          CR_PSW: begin
            old_mode = psw_q[SM_BIT];
            bpsw_q   = v[15:8];
            psw_q    = v[7:0];
            cond_q   = v[0];
            // mode change swaps the live pointer with its shadow
            if (old_mode != v[SM_BIT]) begin
              if (old_mode) begin
                sp_usr_q  = sp_live_q;
                sp_live_q = sp_int_q;
              end else begin
                sp_int_q  = sp_live_q;
                sp_live_q = sp_usr_q;
              end
            end
          end
          CR_CBR: cond_q = v[0];
          CR_SPI: begin
            if (psw_q[SM_BIT]) sp_int_q = v;
            else sp_live_q = v;
          end
          CR_SPU: begin
            if (psw_q[SM_BIT]) sp_live_q = v;
            else sp_usr_q = v;
          end
          CR_SPARE0: spare_q[0] = v;
          CR_SPARE1: spare_q[1] = v;
          CR_BPC:    bpc_q = v;
          CR_BBPSW:  bbpsw_q = v[7:0];
          CR_BBPC:   bbpc_q = v;
          default: ;
        endcase
      end
      OP_READ_SP:  r = sp_live_q;
      OP_WRITE_SP: sp_live_q = v;
      OP_READ_PSW: r = {24'h0, (psw_q & PSW_BYTE_MASK) | {7'h0, cond_q}};
      OP_WRITE_PSW: begin
        psw_q  = v[7:0];
        cond_q = v[0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void note_failure(string what, logic [31:0] exp, logic [31:0] act);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected %08h got %08h", $time, what, exp, act);
  endfunction

  // entered and left at a falling edge
  task automatic offer_word(logic [2:0] op, logic [3:0] num, logic [31:0] v,
                            logic typed, logic [31:0] typed_read);
    int          gap;
    logic [31:0] predicted;
    gap = fast_stretch ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    reg_number  <= num;
    write_value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = next_read_value(op, num, v);
    pending_reads.push_back(typed ? typed_read : predicted);
    @(negedge clk);
  endtask

  // result side
  initial begin : result_side
    int          n;
    logic [31:0] exp;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else if (fast_stretch) begin
        n = 0;
      end else begin
        n = $urandom_range(0, MAX_IDLE);
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      if (pending_reads.size() == 0) begin
        note_failure("word with nothing pending", '0, read_value);
      end else begin
        exp = pending_reads.pop_front();
        if (read_value !== exp) note_failure("read_value mismatch", exp, read_value);
      end
      @(negedge clk);
    end
  end

  initial begin : request_side
    stim_row_t   directed_rows [N_DIRECTED];
    logic [3:0]  known_regs [9];
    int          pick;
    logic [2:0]  op;
    logic [3:0]  num;
    logic [31:0] val;
    directed_rows = '{
      '{OP_READ_CR,   CR_PSW,      32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_WRITE_SP,  CR_PSW,      32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_SPI,      32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{OP_WRITE_CR,  CR_PSW,      32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_PSW,      32'h0000_0000, 1'b1, 32'h0000_c1c1},
      '{OP_READ_CR,   CR_SPI,      32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_WRITE_CR,  CR_SPU,      32'h1234_5678, 1'b1, 32'h0000_0000},
      '{OP_WRITE_PSW, CR_PSW,      32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_SPU,      32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_READ_PSW,  CR_PSW,      32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_WRITE_CR,  CR_PSW,      32'h0000_0080, 1'b1, 32'h0000_0000},
      '{OP_WRITE_CR,  CR_PSW,      32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_READ_SP,   CR_PSW,      32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_WRITE_CR,  CR_BPC,      32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_BPC,      32'h0000_0000, 1'b1, 32'hffff_fffe},
      '{OP_WRITE_CR,  CR_BBPC,     32'h0000_0001, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_BBPC,     32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_WRITE_CR,  CR_BBPSW,    32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_BBPSW,    32'h0000_0000, 1'b1, 32'h0000_00c1},
      '{OP_WRITE_CR,  CR_CBR,      32'h0000_0001, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_CBR,      32'h0000_0000, 1'b1, 32'h0000_0001},
      '{OP_WRITE_CR,  CR_SPARE0,   32'ha5a5_a5a5, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_SPARE0,   32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_WRITE_CR,  CR_UNUSED15, 32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_READ_CR,   CR_UNUSED15, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_RSVD6,     CR_PSW,      32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_RSVD7,     CR_UNUSED15, 32'hffff_ffff, 1'b1, 32'h0000_0000}
    };
    known_regs = '{CR_PSW, CR_CBR, CR_SPI, CR_SPU, CR_SPARE0, CR_SPARE1,
                   CR_BPC, CR_BBPSW, CR_BBPC};
    rst         = 1'b1;
    req_valid   = 1'b0;
    operation   = OP_READ_CR;
    reg_number  = CR_PSW;
    write_value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].op, directed_rows[i].num, directed_rows[i].value,
                 directed_rows[i].typed, directed_rows[i].read);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 200) fast_stretch = 1'b1;
      if (k == 300) fast_stretch = 1'b0;
      // long result hold-off while words keep coming
      if (k == 500) begin
        rsp_hold_cycles = 120;
        fast_stretch    = 1'b1;
      end
      if (k == 540) fast_stretch = 1'b0;
      // drain before going on
      if (k == 700) begin
        req_valid <= 1'b0;
        while (pending_reads.size() != 0) @(negedge clk);
      end

      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_READ_CR;
      else if (pick < 55) op = OP_WRITE_CR;
      else if (pick < 62) op = OP_READ_SP;
      else if (pick < 69) op = OP_WRITE_SP;
      else if (pick < 77) op = OP_READ_PSW;
      else if (pick < 93) op = OP_WRITE_PSW;
      else if (pick < 97) op = OP_RSVD6;
      else                op = OP_RSVD7;

      if ($urandom_range(0, 4) != 0) num = known_regs[$urandom_range(0, 8)];
      else num = 4'($urandom_range(0, 15));

      pick = $urandom_range(0, 9);
      if (pick == 0)      val = '0;
      else if (pick == 1) val = '1;
      else                val = $urandom;

      offer_word(op, num, val, 1'b0, '0);
    end

    req_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
